FILE: hw/rtl/assert_macros.svh
// Assertion macros for the heap RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BTK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap check failed");

// antecedent implies consequent in the next cycle
`define BTK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap check failed");

`endif

FILE: hw/rtl/btk_pkg.sv
// Types, codes and helpers for the bounded top-k heap.
// No dependencies; imported by btk_ctrl, btk_datapath and bounded_topk_heap.
`default_nettype none

package btk_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 31;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0]  CFG_HEAP_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_CAPACITY   = 2'd1;
    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [1:0] {
        FUNC_PUSH    = 2'd0,
        FUNC_POP     = 2'd1,
        FUNC_REPLACE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } node_t;

    typedef struct packed {
        func_t                     func;
        logic signed [VALUE_W-1:0] in_value;
        logic [INDEX_W-1:0]        in_index;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic [INDEX_W-1:0]        popped_index;
        logic signed [VALUE_W-1:0] top_value;
        logic [INDEX_W-1:0]        top_index;
        logic [COUNT_W-1:0]        fill_count;
        logic                      was_dropped;
        logic                      pop_error;
    } rsp_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LATCH,
        CMD_APPEND,
        CMD_TOPSET,
        CMD_DROP,
        CMD_PERR,
        CMD_POP,
        CMD_LAST,
        CMD_SD_READ,
        CMD_SD_MOVE,
        CMD_SU_READ,
        CMD_SU_MOVE,
        CMD_PUT,
        CMD_CLEAR,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  empty;
        logic  push_accept;
        logic  has_child;
        logic  at_root;
        logic  sd_stop;
        logic  su_stop;
    } status_t;

    // a strictly better than b for the selected heap kind
    function automatic logic better(input logic kind,
                                    input logic signed [VALUE_W-1:0] a,
                                    input logic signed [VALUE_W-1:0] b);
        return kind ? (a > b) : (a < b);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/btk_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies; holds the heap node array.
`default_nettype none

module btk_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/btk_ctrl.sv
// Heap controller: sequences one operation through dispatch and sift steps.
// Depends on btk_pkg; drives commands into btk_datapath.
`default_nettype none

module btk_ctrl import btk_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LAST,
        ST_SD_RD,
        ST_SD_CMP,
        ST_SU_RD,
        ST_SU_CMP,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_IDLE;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = CMD_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.func)
                    FUNC_PUSH:
                    begin
                        priority if (!status.full)
                        begin
                            cmd        = CMD_APPEND;
                            state_next = ST_SU_RD;
                        end
                        else if (status.push_accept)
                        begin
                            cmd        = CMD_TOPSET;
                            state_next = ST_SD_RD;
                        end
                        else
                        begin
                            cmd        = CMD_DROP;
                            state_next = ST_EMIT;
                        end
                    end
                    FUNC_POP:
                    begin
                        if (status.empty)
                        begin
                            cmd        = CMD_PERR;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            cmd        = CMD_POP;
                            state_next = ST_LAST;
                        end
                    end
                    FUNC_REPLACE:
                    begin
                        cmd        = CMD_TOPSET;
                        state_next = ST_SD_RD;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd        = CMD_CLEAR;
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_LAST:
            begin
                cmd        = CMD_LAST;
                state_next = ST_SD_RD;
            end
            ST_SD_RD:
            begin
                if (status.has_child)
                begin
                    cmd        = CMD_SD_READ;
                    state_next = ST_SD_CMP;
                end
                else
                begin
                    cmd        = CMD_PUT;
                    state_next = ST_EMIT;
                end
            end
            ST_SD_CMP:
            begin
                if (status.sd_stop)
                begin
                    cmd        = CMD_PUT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd        = CMD_SD_MOVE;
                    state_next = ST_SD_RD;
                end
            end
            ST_SU_RD:
            begin
                if (status.at_root)
                begin
                    cmd        = CMD_PUT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd        = CMD_SU_READ;
                    state_next = ST_SU_CMP;
                end
            end
            ST_SU_CMP:
            begin
                if (status.su_stop)
                begin
                    cmd        = CMD_PUT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd        = CMD_SU_MOVE;
                    state_next = ST_SU_RD;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd            = CMD_EMIT;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/btk_datapath.sv
// Heap datapath: node RAM, sift pointer, moving node, count, top copy, result register.
// Depends on btk_pkg and btk_ram; commanded by btk_ctrl.
`default_nettype none

module btk_datapath import btk_pkg::*; #(
    parameter int HEAP_DEPTH = 64,
    localparam int AW = $clog2(HEAP_DEPTH),
    localparam int CW = $clog2(HEAP_DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cmd_t          cmd,
    input  wire req_t          req_data,
    input  wire logic          heap_kind,
    input  wire logic [CW-1:0] eff_cap,
    output status_t            status,
    output rsp_t               rsp_data
);

    func_t         func_reg;
    node_t         x_reg;
    logic [AW-1:0] i_reg;
    logic [CW-1:0] count_reg;
    node_t         top_reg;
    node_t         popped_reg;
    logic          dropped_reg;
    logic          perr_reg;
    rsp_t          rsp_reg;

    logic [AW+1:0] left_idx, right_idx, count_ext;
    logic [AW-1:0] parent_idx, last_idx, child_idx;
    logic          right_ok, pick_left;
    node_t         child_node;

    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    node_t         wdata, rd_a, rd_b;

    assign left_idx   = {1'b0, i_reg, 1'b1};
    assign right_idx  = left_idx + (AW+2)'(1);
    assign count_ext  = (AW+2)'(count_reg);
    assign parent_idx = (i_reg - AW'(1)) >> 1;
    assign last_idx   = AW'(count_reg - CW'(1));

    assign right_ok   = right_idx < count_ext;
    assign pick_left  = !right_ok || better(heap_kind, rd_a.value, rd_b.value);
    assign child_node = pick_left ? rd_a : rd_b;
    assign child_idx  = pick_left ? left_idx[AW-1:0] : right_idx[AW-1:0];

    always_comb
    begin
        status.func        = func_reg;
        status.full        = count_reg >= eff_cap;
        status.empty       = count_reg == '0;
        status.push_accept = better(heap_kind, top_reg.value, x_reg.value);
        status.has_child   = left_idx < count_ext;
        status.at_root     = i_reg == '0;
        status.sd_stop     = better(heap_kind, x_reg.value, child_node.value);
        status.su_stop     = better(heap_kind, rd_a.value, x_reg.value);
    end

    // hole method: the moving node is written only where the sift stops
    always_comb
    begin
        we      = 1'b0;
        waddr   = i_reg;
        wdata   = x_reg;
        raddr_a = left_idx[AW-1:0];
        raddr_b = right_idx[AW-1:0];
        unique case (cmd)
            CMD_PUT:
            begin
                we = 1'b1;
            end
            CMD_SD_MOVE:
            begin
                we    = 1'b1;
                wdata = child_node;
            end
            CMD_SU_MOVE:
            begin
                we    = 1'b1;
                wdata = rd_a;
            end
            CMD_POP:
            begin
                raddr_a = last_idx;
            end
            CMD_SU_READ:
            begin
                raddr_a = parent_idx;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    btk_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            top_reg   <= '0;
        end
        else
        begin
            unique case (cmd)
                CMD_APPEND:
                begin
                    count_reg <= count_reg + CW'(1);
                end
                CMD_POP:
                begin
                    count_reg <= count_reg - CW'(1);
                end
                CMD_CLEAR:
                begin
                    count_reg     <= '0;
                    top_reg.value <= x_reg.value;
                    top_reg.index <= '0;
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
            if (we && (waddr == '0))
            begin
                top_reg <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LATCH:
            begin
                func_reg    <= req_data.func;
                x_reg.value <= req_data.in_value;
                x_reg.index <= req_data.in_index;
                popped_reg  <= '0;
                dropped_reg <= 1'b0;
                perr_reg    <= 1'b0;
            end
            CMD_APPEND:
            begin
                i_reg <= count_reg[AW-1:0];
            end
            CMD_TOPSET:
            begin
                i_reg <= '0;
            end
            CMD_DROP:
            begin
                dropped_reg <= 1'b1;
            end
            CMD_PERR:
            begin
                perr_reg <= 1'b1;
            end
            CMD_POP:
            begin
                popped_reg <= top_reg;
                i_reg      <= '0;
            end
            CMD_LAST:
            begin
                // last node moves to the top; an emptied heap shows a zero top
                x_reg <= (count_reg == '0) ? '0 : rd_a;
            end
            CMD_SD_MOVE:
            begin
                i_reg <= child_idx;
            end
            CMD_SU_MOVE:
            begin
                i_reg <= parent_idx;
            end
            CMD_EMIT:
            begin
                rsp_reg.popped_value <= popped_reg.value;
                rsp_reg.popped_index <= popped_reg.index;
                rsp_reg.top_value    <= top_reg.value;
                rsp_reg.top_index    <= top_reg.index;
                rsp_reg.fill_count   <= COUNT_W'(count_reg);
                rsp_reg.was_dropped  <= dropped_reg;
                rsp_reg.pop_error    <= perr_reg;
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bounded_topk_heap.sv
// Top level of the bounded top-k heap: configuration registers, controller, datapath.
// Depends on btk_pkg, btk_ctrl, btk_datapath and assert_macros.svh.
//
// Bounded binary heap of (value, index) nodes held in a RAM of HEAP_DEPTH entries.
// One operation is in flight at a time. Clear, a rejected push and a pop on an empty
// heap go from dispatch straight to emit. Push and replace_top sift through the heap one
// level at a time, and pop first reads the last node; each level takes a RAM read state
// and a compare and write state. The result sits in an output register, so the next item
// is taken while the result waits.
// Configuration writes are always ready and are meant for idle periods.
`default_nettype none

`include "assert_macros.svh"

module bounded_topk_heap import btk_pkg::*; #(
    parameter int HEAP_DEPTH = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire req_t                  req_data,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output rsp_t                       rsp_data
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic                  heap_kind_reg;
    logic [CFG_DATA_W-1:0] capacity_reg;
    logic [CW-1:0]         eff_cap;
    cmd_t                  cmd;
    status_t               status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_kind_reg <= 1'b0;
            capacity_reg  <= CAPACITY_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEAP_KIND:
                begin
                    heap_kind_reg <= cfg_data[0];
                end
                CFG_CAPACITY:
                begin
                    capacity_reg <= cfg_data;
                end
                default:
                begin
                    capacity_reg <= capacity_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (int'(capacity_reg) > HEAP_DEPTH)
        begin
            eff_cap = CW'(HEAP_DEPTH);
        end
        else
        begin
            eff_cap = CW'(capacity_reg);
        end
    end

    btk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    btk_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_data  (req_data),
        .heap_kind (heap_kind_reg),
        .eff_cap   (eff_cap),
        .status    (status),
        .rsp_data  (rsp_data)
    );

    `BTK_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)
    `BTK_ASSERT_IMP(a_pop_error_clean, clk, rst_n, rsp_valid && rsp_data.pop_error, rsp_data.popped_value == '0 && rsp_data.popped_index == '0 && rsp_data.fill_count == '0 && !rsp_data.was_dropped)
    `BTK_ASSERT_IMP(a_drop_clean, clk, rst_n, rsp_valid && rsp_data.was_dropped, rsp_data.popped_value == '0 && rsp_data.popped_index == '0 && !rsp_data.pop_error)

endmodule

`default_nettype wire

FILE: verif/tb_bounded_topk_heap.sv
// Self-checking testbench for bounded_topk_heap: directed item table, then random phases
// across heap kinds and capacities, each result checked against a behavioral heap or the row's report.
// Depends on btk_pkg and the bounded_topk_heap RTL.
`timescale 1ns / 100ps

module tb_bounded_topk_heap;
    import btk_pkg::*;

    localparam int DEPTH = 64;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 160;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam int VAL_MAX = 32'sh7fff_ffff;
    localparam int VAL_MIN = 32'sh8000_0000;
    localparam logic [INDEX_W-1:0] IDX_MAX = 31'h7fff_ffff;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req_data;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp_data;

    // behavioral heap
    node_t                 heap_mem [DEPTH];
    int                    heap_fill;
    logic                  kind_reg;
    logic [CFG_DATA_W-1:0] cap_reg;

    rsp_t     due_reports [$];
    dir_row_t dir_rows [$];
    rsp_t     oldest;
    bit       steady;
    int       fail_count;
    int       stall_cycles;

    bounded_topk_heap #(.HEAP_DEPTH(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit outranks(input int a, input int b);
        return kind_reg ? (a > b) : (a < b);
    endfunction

    function automatic void swap_slots(input int a, input int b);
        node_t t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void push_down(input int start);
        int i;
        int l;
        int m;
        i = start;
        while (2 * i + 1 < heap_fill)
        begin
            l = 2 * i + 1;
            m = (l + 1 >= heap_fill || outranks(heap_mem[l].value, heap_mem[l + 1].value))
                ? l : l + 1;
            if (outranks(heap_mem[i].value, heap_mem[m].value))
                break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    function automatic void bubble_up(input int start);
        int i;
        int p;
        i = start;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (outranks(heap_mem[p].value, heap_mem[i].value))
                break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    // applies one item to the behavioral heap and returns the report it yields
    function automatic rsp_t heap_outcome(input req_t item);
        rsp_t res;
        int   lim;
        int   head;
        int   v;
        res = '0;
        v = item.in_value;
        lim = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        case (item.func)
            FUNC_PUSH:
            begin
                head = heap_mem[0].value;
                if (heap_fill < lim)
                begin
                    heap_mem[heap_fill].value = item.in_value;
                    heap_mem[heap_fill].index = item.in_index;
                    bubble_up(heap_fill);
                    heap_fill++;
                end
                else if (kind_reg ? (head <= v) : (head >= v))
                    res.was_dropped = 1'b1;
                else
                begin
                    heap_mem[0].value = item.in_value;
                    heap_mem[0].index = item.in_index;
                    push_down(0);
                end
            end
            FUNC_POP:
            begin
                if (heap_fill == 0)
                    res.pop_error = 1'b1;
                else
                begin
                    res.popped_value = heap_mem[0].value;
                    res.popped_index = heap_mem[0].index;
                    heap_mem[0] = heap_mem[heap_fill - 1];
                    heap_fill--;
                    heap_mem[heap_fill] = '0;
                    push_down(0);
                end
            end
            FUNC_REPLACE:
            begin
                heap_mem[0].value = item.in_value;
                heap_mem[0].index = item.in_index;
                push_down(0);
            end
            default:
            begin
                heap_fill = 0;
                for (int k = 0; k < DEPTH; k++)
                begin
                    heap_mem[k].value = item.in_value;
                    heap_mem[k].index = '0;
                end
            end
        endcase
        res.top_value = heap_mem[0].value;
        res.top_index = heap_mem[0].index;
        res.fill_count = heap_fill[COUNT_W-1:0];
        return res;
    endfunction

    function automatic rsp_t report(input int pv, input logic [INDEX_W-1:0] pi, input int tv,
                                    input logic [INDEX_W-1:0] ti, input int cnt,
                                    input bit drop, input bit perr);
        rsp_t r;
        r.popped_value = pv;
        r.popped_index = pi;
        r.top_value = tv;
        r.top_index = ti;
        r.fill_count = cnt[COUNT_W-1:0];
        r.was_dropped = drop;
        r.pop_error = perr;
        return r;
    endfunction

    function automatic void add_row(input func_t f, input int v, input logic [INDEX_W-1:0] ix,
                                    input bit typed = 1'b0, input rsp_t want = '0);
        dir_row_t row;
        row.item.func = f;
        row.item.in_value = v;
        row.item.in_index = ix;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    task automatic send_item(input req_t item, input bit typed, input rsp_t want);
        rsp_t got;
        req_valid <= 1'b1;
        req_data <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        got = heap_outcome(item);
        due_reports.push_back(typed ? want : got);
        if (!steady && $urandom_range(99) < 17)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(6, 1))
                @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_KIND)
            kind_reg = data[0];
        else if (idx == CFG_CAPACITY)
            cap_reg = data;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
        rsp_ready <= steady || ($urandom_range(99) >= 17);

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("bounded_topk_heap verification failed");
            $finish;
        end
        else if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_reports.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            end
            else
            begin
                oldest = due_reports.pop_front();
                check_field("popped_value", oldest.popped_value, rsp_data.popped_value);
                check_field("popped_index", oldest.popped_index, rsp_data.popped_index);
                check_field("top_value", oldest.top_value, rsp_data.top_value);
                check_field("top_index", oldest.top_index, rsp_data.top_index);
                check_field("fill_count", oldest.fill_count, rsp_data.fill_count);
                check_field("was_dropped", oldest.was_dropped, rsp_data.was_dropped);
                check_field("pop_error", oldest.pop_error, rsp_data.pop_error);
            end
        end
    end

    initial
    begin
        int                    pct;
        int                    vmode;
        int                    pushw;
        int                    v;
        bit                    fill;
        logic                  kind_sel;
        logic [CFG_DATA_W-1:0] cap_sel;
        logic [CFG_DATA_W-1:0] kind_data;
        req_t                  item;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_ready = 1'b0;
        steady = 1'b0;
        fail_count = 0;
        stall_cycles = 0;
        for (int k = 0; k < DEPTH; k++)
            heap_mem[k] = '0;
        heap_fill = 0;
        kind_reg = 1'b0;
        cap_reg = CAPACITY_RESET;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // min heap, capacity 64 after reset
        add_row(FUNC_POP, 0, 0, 1'b1, report(0, 0, 0, 0, 0, 1'b0, 1'b1));
        add_row(FUNC_REPLACE, 5, 9, 1'b1, report(0, 0, 5, 9, 0, 1'b0, 1'b0));
        add_row(FUNC_PUSH, VAL_MAX, IDX_MAX, 1'b1, report(0, 0, VAL_MAX, IDX_MAX, 1, 1'b0, 1'b0));
        add_row(FUNC_PUSH, VAL_MIN, 0, 1'b1, report(0, 0, VAL_MIN, 0, 2, 1'b0, 1'b0));
        add_row(FUNC_PUSH, VAL_MIN, 3);
        add_row(FUNC_POP, 0, 0);
        add_row(FUNC_POP, 0, 0);
        add_row(FUNC_POP, 0, 0);
        add_row(FUNC_POP, 0, 0, 1'b1, report(0, 0, 0, 0, 0, 1'b0, 1'b1));
        add_row(FUNC_CLEAR, -1, 0, 1'b1, report(0, 0, -1, 0, 0, 1'b0, 1'b0));
        add_row(FUNC_POP, 0, 0, 1'b1, report(0, 0, -1, 0, 0, 1'b0, 1'b1));
        add_row(FUNC_REPLACE, 7, 1, 1'b1, report(0, 0, 7, 1, 0, 1'b0, 1'b0));
        add_row(FUNC_PUSH, 4, 1);
        add_row(FUNC_PUSH, 4, 2);
        add_row(FUNC_PUSH, 4, 3);
        add_row(FUNC_PUSH, 2, 4);
        add_row(FUNC_REPLACE, 4, 5);
        add_row(FUNC_REPLACE, 9, 6);
        add_row(FUNC_POP, 0, 0);
        add_row(FUNC_PUSH, VAL_MIN + 1, 31'h5555_5555);
        add_row(FUNC_PUSH, -1, 31'h2aaa_aaaa);
        add_row(FUNC_POP, 0, 0);
        add_row(FUNC_CLEAR, VAL_MAX, IDX_MAX, 1'b1, report(0, 0, VAL_MAX, 0, 0, 1'b0, 1'b0));
        add_row(FUNC_REPLACE, 0, 0, 1'b1, report(0, 0, 0, 0, 0, 1'b0, 1'b0));
        foreach (dir_rows[r])
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

        // phases run back to back without clear: lowered capacity and kind flips hit live data
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:  begin kind_sel = 1'b0; cap_sel = 7'd64;  vmode = 0; end
                1:  begin kind_sel = 1'b0; cap_sel = 7'd3;   vmode = 0; end
                2:  begin kind_sel = 1'b1; cap_sel = 7'd3;   vmode = 0; end
                3:  begin kind_sel = 1'b1; cap_sel = 7'd1;   vmode = 1; end
                4:  begin kind_sel = 1'b0; cap_sel = 7'd0;   vmode = 0; end
                5:  begin kind_sel = 1'b1; cap_sel = 7'd127; vmode = 2; end
                6:  begin kind_sel = 1'b0; cap_sel = 7'd2;   vmode = 1; end
                7:  begin kind_sel = 1'b1; cap_sel = 7'd64;  vmode = 0; end
                8:  begin kind_sel = 1'b0; cap_sel = 7'd100; vmode = 2; end
                9:  begin kind_sel = 1'b1; cap_sel = 7'd7;   vmode = 0; end
                10: begin kind_sel = 1'b0; cap_sel = 7'd5;   vmode = 1; end
                default:
                begin
                    kind_sel = $urandom_range(1);
                    cap_sel = $urandom_range(127);
                    vmode = 0;
                end
            endcase
            kind_data = $urandom_range(127);
            kind_data[0] = kind_sel;
            write_reg(CFG_HEAP_KIND, kind_data);
            write_reg(CFG_CAPACITY, cap_sel);
            if (p == 4)
                write_reg(CFG_SPARE, $urandom_range(127));
            fill = (cap_sel >= 64);
            pushw = fill ? 75 : 45;
            steady = (p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                pct = $urandom_range(99);
                if (pct < pushw)
                    item.func = FUNC_PUSH;
                else if (pct < pushw + 20)
                    item.func = FUNC_POP;
                else if (pct < 99 || fill)
                    item.func = FUNC_REPLACE;
                else
                    item.func = FUNC_CLEAR;
                case (vmode)
                    0: v = int'($urandom_range(8)) - 4;
                    2: v = int'($urandom_range(2000)) - 1000;
                    default:
                    begin
                        if ($urandom_range(7) == 0)
                        begin
                            case ($urandom_range(3))
                                0: v = VAL_MIN;
                                1: v = VAL_MAX;
                                2: v = 0;
                                default: v = -1;
                            endcase
                        end
                        else
                            v = $urandom;
                    end
                endcase
                item.in_value = v;
                item.in_index = $urandom;
                send_item(item, 1'b0, '0);
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("bounded_topk_heap verification clean");
        else
            $display("bounded_topk_heap verification failed");
        $finish;
    end

endmodule
